FILE: hdl/rle16_pkg.sv
// ----------------------------------------------------------------------------
// rle16_pkg: shared types and constants for the run-length encoder
// Defaults for the word width and queue depth, and the control and status
// structs that pass between the front, the queue and the back.
// ----------------------------------------------------------------------------
package rle16_pkg;

    localparam int WORD_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // one queue entry carries one or two code words
    typedef struct packed {
        logic two;
        logic stream_last;
    } rle16_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } rle16_qstat_t;

endpackage

FILE: hdl/run_length_encoder_16bit_top.sv
// The first code word of an input beat passes the entry queue and the output register.
// Throughput: one input beat per cycle while the entry queue has room; the output
// port moves one code word per cycle while m_tready is high; pairs go out word by word.
// The queue (QUEUE_DEPTH entries) lets front and back stall independently.
// Reset: rst_n clears the run state (new run pending, tally zero), the queue and
// the output valid and phase flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// run_length_encoder_16bit_top: run-length encoder with double-value escape
// Passes the first two copies of a word through, counts further copies and
// emits the count when the run ends, saturates or the stream ends.
// ----------------------------------------------------------------------------
module run_length_encoder_16bit_top #(
    parameter int WORD_BITS   = rle16_pkg::WORD_BITS_DEF,
    parameter int QUEUE_DEPTH = rle16_pkg::QUEUE_DEPTH_DEF,
    localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // symbol_in
    input  logic                  s_tlast,   // stream_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // code_word
    output logic                  m_tuser,   // item_last
    output logic                  m_tlast    // stream_last
);
    import rle16_pkg::*;

    logic                 push;
    logic                 pop;
    logic [WORD_BITS-1:0] fr_word0;
    logic [WORD_BITS-1:0] fr_word1;
    rle16_ctl_t           fr_ctl;
    logic [WORD_BITS-1:0] q_word0;
    logic [WORD_BITS-1:0] q_word1;
    rle16_ctl_t           q_ctl;
    rle16_qstat_t         q_stat;

    rle16_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_word  (s_tdata[WORD_BITS-1:0]),
        .in_last  (s_tlast),
        .q_stat   (q_stat),
        .in_ready (s_tready),
        .push     (push),
        .word0    (fr_word0),
        .word1    (fr_word1),
        .ctl      (fr_ctl)
    );

    rle16_queue #(
        .WORD_BITS   (WORD_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_word0 (fr_word0),
        .wr_word1 (fr_word1),
        .wr_ctl   (fr_ctl),
        .pop      (pop),
        .rd_word0 (q_word0),
        .rd_word1 (q_word1),
        .rd_ctl   (q_ctl),
        .q_stat   (q_stat)
    );

    rle16_back #(
        .WORD_BITS  (WORD_BITS),
        .TDATA_BITS (TDATA_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_word0        (q_word0),
        .rd_word1        (q_word1),
        .rd_ctl          (q_ctl),
        .q_stat          (q_stat),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data        (m_tdata),
        .out_item_last   (m_tuser),
        .out_stream_last (m_tlast)
    );

    // second word of a pair is already queued, so the output stays occupied
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |=> m_tvalid)
        else $error("second code word of a pair missing");

    a_stream_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("stream_last on a beat that does not end its item");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("entry pushed into a full queue");

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("entry popped from an empty queue");

endmodule

FILE: hdl/rle16_front.sv
// ----------------------------------------------------------------------------
// rle16_front: run tracking and classification
// Compares each accepted word with the run held, updates the tally and
// builds the zero, one or two code words that the word causes.
// ----------------------------------------------------------------------------
module rle16_front #(
    parameter int WORD_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [WORD_BITS-1:0]     in_word,
    input  logic                     in_last,
    input  rle16_pkg::rle16_qstat_t  q_stat,
    output logic                     in_ready,
    output logic                     push,
    output logic [WORD_BITS-1:0]     word0,
    output logic [WORD_BITS-1:0]     word1,
    output rle16_pkg::rle16_ctl_t    ctl
);
    import rle16_pkg::*;

    localparam logic [WORD_BITS-1:0] TALLY_ONE   = {{(WORD_BITS-1){1'b0}}, 1'b1};
    localparam logic [WORD_BITS-1:0] TALLY_LIMIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [WORD_BITS-1:0] prev_reg, prev_next;
    logic [WORD_BITS-1:0] tally_reg, tally_next;
    logic                 restart_reg, restart_next;

    logic                 accept;
    logic                 match;
    logic                 any_res;
    logic [WORD_BITS-1:0] tally_inc;
    logic [WORD_BITS-1:0] tally_after;
    logic [WORD_BITS-1:0] prev_after;
    logic                 restart_after;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && any_res;

    always_comb
    begin
        match         = (in_word == prev_reg) && !restart_reg;
        tally_inc     = tally_reg + TALLY_ONE;
        any_res       = 1'b0;
        ctl.two       = 1'b0;
        word0         = in_word;
        word1         = in_word;
        tally_after   = tally_reg;
        prev_after    = prev_reg;
        restart_after = restart_reg;
        if (match)
        begin
            tally_after = tally_inc;
            if (tally_inc == TALLY_ONE)
            begin
                any_res = 1'b1;
            end
            else if (tally_inc == TALLY_LIMIT)
            begin
                any_res       = 1'b1;
                word0         = tally_reg;
                tally_after   = '0;
                restart_after = 1'b1;
            end
        end
        else
        begin
            any_res       = 1'b1;
            restart_after = 1'b0;
            prev_after    = in_word;
            tally_after   = '0;
            if (tally_reg != '0)
            begin
                ctl.two = 1'b1;
                word0   = tally_reg - TALLY_ONE;
            end
        end
        // flush a pending count on the final word; tally_after - 1 equals tally_reg here
        if (in_last && (tally_after != '0) && !ctl.two)
        begin
            if (any_res)
            begin
                ctl.two = 1'b1;
                word1   = tally_reg;
            end
            else
            begin
                any_res = 1'b1;
                word0   = tally_reg;
            end
        end
        ctl.stream_last = in_last;
    end

    always_comb
    begin
        prev_next    = prev_reg;
        tally_next   = tally_reg;
        restart_next = restart_reg;
        if (accept)
        begin
            if (in_last)
            begin
                prev_next    = '0;
                tally_next   = '0;
                restart_next = 1'b1;
            end
            else
            begin
                prev_next    = prev_after;
                tally_next   = tally_after;
                restart_next = restart_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            tally_reg   <= '0;
            restart_reg <= 1'b1;
        end
        else
        begin
            prev_reg    <= prev_next;
            tally_reg   <= tally_next;
            restart_reg <= restart_next;
        end
    end

endmodule

FILE: hdl/rle16_queue.sv
// ----------------------------------------------------------------------------
// rle16_queue: entry queue between front and back
// Holds classified entries so that either side can stall on its own.
// ----------------------------------------------------------------------------
module rle16_queue #(
    parameter int WORD_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WORD_BITS-1:0]     wr_word0,
    input  logic [WORD_BITS-1:0]     wr_word1,
    input  rle16_pkg::rle16_ctl_t    wr_ctl,
    input  logic                     pop,
    output logic [WORD_BITS-1:0]     rd_word0,
    output logic [WORD_BITS-1:0]     rd_word1,
    output rle16_pkg::rle16_ctl_t    rd_ctl,
    output rle16_pkg::rle16_qstat_t  q_stat
);
    import rle16_pkg::*;

    localparam int CTL_BITS   = $bits(rle16_ctl_t);
    localparam int ENTRY_BITS = 2 * WORD_BITS + CTL_BITS;
    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

    logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [ENTRY_BITS-1:0] rd_entry;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_FULL);

    assign rd_entry = mem[rd_ptr_reg];
    assign rd_word0 = rd_entry[WORD_BITS-1:0];
    assign rd_word1 = rd_entry[2*WORD_BITS-1:WORD_BITS];
    assign rd_ctl   = rd_entry[ENTRY_BITS-1:2*WORD_BITS];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= {wr_ctl, wr_word1, wr_word0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/rle16_back.sv
// ----------------------------------------------------------------------------
// rle16_back: result serialiser
// Takes queue entries apart into single code words and drives the
// registered output beat.
// ----------------------------------------------------------------------------
module rle16_back #(
    parameter int WORD_BITS  = 16,
    parameter int TDATA_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [WORD_BITS-1:0]     rd_word0,
    input  logic [WORD_BITS-1:0]     rd_word1,
    input  rle16_pkg::rle16_ctl_t    rd_ctl,
    input  rle16_pkg::rle16_qstat_t  q_stat,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [TDATA_BITS-1:0]    out_data,
    output logic                     out_item_last,
    output logic                     out_stream_last
);
    import rle16_pkg::*;

    logic                 valid_reg, valid_next;
    logic                 phase_reg, phase_next;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic                 item_last_reg, item_last_next;
    logic                 stream_last_reg, stream_last_next;
    logic                 load;
    logic                 entry_done;

    assign load       = !q_stat.empty && (!valid_reg || out_ready);
    assign entry_done = phase_reg || !rd_ctl.two;
    assign pop        = load && entry_done;

    always_comb
    begin
        valid_next       = valid_reg;
        phase_next       = phase_reg;
        data_next        = data_reg;
        item_last_next   = item_last_reg;
        stream_last_next = stream_last_reg;
        if (load)
        begin
            valid_next       = 1'b1;
            phase_next       = !entry_done;
            data_next        = phase_reg ? rd_word1 : rd_word0;
            item_last_next   = entry_done;
            stream_last_next = entry_done && rd_ctl.stream_last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg        <= data_next;
        item_last_reg   <= item_last_next;
        stream_last_reg <= stream_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    assign out_valid       = valid_reg;
    assign out_data        = TDATA_BITS'(data_reg);
    assign out_item_last   = valid_reg && item_last_reg;
    assign out_stream_last = valid_reg && stream_last_reg;

endmodule

FILE: sim/tb_run_length_encoder_16bit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_encoder_16bit_top: self-checking bench for the RLE encoder
// Drives word streams (directed corners, random runs with noise, a long
// output hold-off and an idle-free tail), predicts the code words beat by
// beat and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_run_length_encoder_16bit_top;

    localparam int WORD_BITS      = rle16_pkg::WORD_BITS_DEF;
    localparam int TDATA_BITS     = ((WORD_BITS + 7) / 8) * 8;
    localparam int TALLY_LIMIT    = 1 << (WORD_BITS - 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 300;

    typedef struct packed {
        logic [WORD_BITS-1:0] code;
        logic                 item_last;
        logic                 stream_last;
    } code_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata = '0;   // symbol_in
    logic                  s_tlast = 1'b0; // stream_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;        // code_word
    logic                  m_tuser;        // item_last
    logic                  m_tlast;        // stream_last

    code_beat_t           expected_codes[$];
    logic [WORD_BITS-1:0] run_word = '0;
    logic                 run_pending = 1'b1;
    logic [WORD_BITS-1:0] repeat_count = '0;

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;

    run_length_encoder_16bit_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic encode_symbol(input logic [WORD_BITS-1:0] sym, input logic fin);
        code_beat_t beats[2];
        int         n;
        n = 0;
        if (sym == run_word && !run_pending)
        begin
            repeat_count = repeat_count + 1'b1;
            if (repeat_count == 1)
            begin
                beats[n] = '{sym, 1'b0, 1'b0};
                n++;
            end
            else if (repeat_count >= TALLY_LIMIT)
            begin
                beats[n] = '{repeat_count - 1'b1, 1'b0, 1'b0};
                n++;
                repeat_count = '0;
                run_pending = 1'b1;
            end
        end
        else
        begin
            run_pending = 1'b0;
            if (repeat_count > 0)
            begin
                beats[n] = '{repeat_count - 1'b1, 1'b0, 1'b0};
                n++;
                repeat_count = '0;
            end
            run_word = sym;
            beats[n] = '{sym, 1'b0, 1'b0};
            n++;
        end
        if (fin)
        begin
            if (repeat_count > 0 && n < 2)
            begin
                beats[n] = '{repeat_count - 1'b1, 1'b0, 1'b0};
                n++;
            end
            if (n > 0)
                beats[n-1].stream_last = 1'b1;
            run_word = '0;
            run_pending = 1'b1;
            repeat_count = '0;
        end
        if (n > 0)
            beats[n-1].item_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_codes.insert(expected_codes.size(), beats[i]);
    endtask

    // call at a rising edge; returns at the edge that accepts the beat
    task automatic send_symbol(input logic [WORD_BITS-1:0] sym, input logic fin);
        int gap;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_symbol(sym, fin);
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_run(input logic [WORD_BITS-1:0] sym, input int len,
                            input logic fin, input int cut);
        for (int k = 1; k <= len; k++)
            send_symbol(sym, (fin && k == len) || k == cut);
    endtask

    task automatic test_directed_cases();
        // first word after reset equals the cleared history: still a literal
        send_run(16'h0000, 3, 1'b0, 0);
        send_run(16'hFFFF, 5, 1'b1, 0);
        send_symbol(16'h1234, 1'b1);
        send_run(16'h5555, 2, 1'b1, 0);
        send_run(16'hAAAA, 3, 1'b0, 0);
        send_symbol(16'h0001, 1'b1);
        send_symbol(16'h8000, 1'b0);
        send_symbol(16'h7FFF, 1'b0);
        send_symbol(16'h8000, 1'b0);
        send_run(16'h7FFF, 3, 1'b1, 0);
        release_input();
    endtask

    task automatic test_random_streams(input int target);
        logic [WORD_BITS-1:0] sym;
        int                   len;
        int                   cut;
        int                   sent;
        sent = 0;
        sym  = '0;
        while (sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_symbol(WORD_BITS'($urandom), $urandom_range(0, 9) == 0);
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: sym = '0;
                    1: sym = '1;
                    2: sym = sym;
                    default: sym = WORD_BITS'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: len = 1;
                    3, 4:    len = 2;
                    5, 6, 7: len = $urandom_range(3, 6);
                    default: len = $urandom_range(7, 40);
                endcase
                cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, len) : 0;
                send_run(sym, len, $urandom_range(0, 7) == 0, cut);
                sent += len;
            end
        end
        release_input();
    endtask

    task automatic test_output_hold_off();
        src_idle = 1'b0;
        hold_req <= 1'b1;
        repeat (40)
            send_symbol(WORD_BITS'($urandom), 1'b0);
        send_symbol(WORD_BITS'($urandom), 1'b1);
        src_idle = 1'b1;
        release_input();
    endtask

    task automatic test_steady_stream();
        logic [WORD_BITS-1:0] sym;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        repeat (30)
        begin
            sym = ($urandom_range(0, 3) == 0) ? '1 : WORD_BITS'($urandom);
            send_run(sym, $urandom_range(1, 6), $urandom_range(0, 9) == 0, 0);
        end
        send_symbol(WORD_BITS'($urandom), 1'b1);
        release_input();
    endtask

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF - 1;
        end
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (snk_idle && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        code_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_codes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat: code %h item_last %b stream_last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = expected_codes.pop_front();
                if (m_tdata[WORD_BITS-1:0] !== want.code)
                begin
                    mismatches++;
                    $display("%0t: code_word expected %h actual %h",
                             $time, want.code, m_tdata);
                end
                if (m_tuser !== want.item_last)
                begin
                    mismatches++;
                    $display("%0t: item_last expected %b actual %b",
                             $time, want.item_last, m_tuser);
                end
                if (m_tlast !== want.stream_last)
                begin
                    mismatches++;
                    $display("%0t: stream_last expected %b actual %b",
                             $time, want.stream_last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d beats outstanding",
                     $time, expected_codes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_streams(680);
        test_output_hold_off();
        test_steady_stream();
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
